@@ rtl/moving_test_pattern_pixel_assert.svh @@
// Assertion macros for the checker file of the moving test pattern block.
// Depends on nothing; the using scope must provide clk and arst_n.
`ifndef MOVING_TEST_PATTERN_PIXEL_ASSERT_SVH
`define MOVING_TEST_PATTERN_PIXEL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define MTP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("moving test pattern check failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define MTP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("moving test pattern check failed");

`endif

@@ rtl/mtp_pkg.sv @@
// Shared constants, stage-enable types and the bar color table of the test pattern.
// Used by the design modules of the block; depends on nothing.
package mtp_pkg;

	localparam int BAR_WIDTH    = 80;
	localparam int CHECK_PERIOD = 30;
	// Frame count modulo twice the period gives the checkerboard phase.
	localparam int CHECK_MOD    = 2 * CHECK_PERIOD;
	localparam int BOX_W        = 96;
	localparam int BOX_H        = 64;

	// Division of a 9-bit coordinate by the 24-pixel square size.
	localparam int CHECK_SHIFT  = 14;
	localparam int CHECK_RECIP  = (1 << CHECK_SHIFT) / 24 + 1;
	localparam int CHECK_PROD_W = 19;

	localparam logic [15:0] CHECK_MASK   = 16'h0841;
	localparam logic [15:0] BOX_COLOR    = 16'hFA9B;
	localparam logic [15:0] COLOR_RED    = 16'hF800;
	localparam logic [15:0] COLOR_GREEN  = 16'h07E0;
	localparam logic [15:0] COLOR_BLUE   = 16'h001F;
	localparam logic [15:0] COLOR_WHITE  = 16'hFFFF;
	localparam logic [15:0] COLOR_BLACK  = 16'h0000;
	localparam logic [15:0] COLOR_YELLOW = 16'hFFE0;

	localparam int BAR_IDX_W = 5;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} mod_en_t;

	typedef struct packed {
		logic s5;
		logic s6;
	} shade_en_t;

	// Bar color for a bar count; the six colors repeat every six bars.
	function automatic logic [15:0] bar_color(input logic [BAR_IDX_W-1:0] idx);
		logic [15:0] c;
		case (idx) inside
			5'd0, 5'd6, 5'd12, 5'd18, 5'd24, 5'd30: c = COLOR_RED;
			5'd1, 5'd7, 5'd13, 5'd19, 5'd25, 5'd31: c = COLOR_GREEN;
			5'd2, 5'd8, 5'd14, 5'd20, 5'd26:        c = COLOR_BLUE;
			5'd3, 5'd9, 5'd15, 5'd21, 5'd27:        c = COLOR_WHITE;
			5'd5, 5'd11, 5'd17, 5'd23, 5'd29:       c = COLOR_YELLOW;
			default:                                c = COLOR_BLACK;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/mtp_modc.sv @@
// Three-stage remainder of a 32-bit word by an elaboration-time constant.
// Depends on mtp_pkg for the stage-enable struct.
module mtp_modc #(
	parameter int MOD = 60
) (
	input  logic                       clk,
	input  mtp_pkg::mod_en_t           en,
	input  logic [31:0]                x,
	output logic [$clog2(MOD+1)-1:0]   r_s4
);

	localparam int RW = $clog2(MOD + 1);
	localparam longint unsigned C0 = 64'd1 % MOD;
	localparam longint unsigned C1 = 64'd256 % MOD;
	localparam longint unsigned C2 = 64'd65536 % MOD;
	localparam longint unsigned C3 = 64'd16777216 % MOD;
	// The byte-weighted sum stays below 1020 * MOD.
	localparam int SW  = $clog2(4 * 255 * MOD);
	localparam int QW  = $clog2(4 * 255);
	localparam longint unsigned RECIP = (64'd1 << SW) / MOD;
	localparam int RCW = SW + 1;
	localparam int PW  = SW + RCW;

	logic [SW-1:0] sum_d;
	logic [SW-1:0] sum_s2;
	logic [SW-1:0] sum_s3;
	logic [PW-1:0] prod;
	logic [QW-1:0] q_s3;
	logic [SW-1:0] diff;

	// Each byte is folded by its weight modulo MOD; the sum is congruent to x.
	always_comb begin
		sum_d = SW'(x[7:0]) * SW'(C0) + SW'(x[15:8]) * SW'(C1)
			+ SW'(x[23:16]) * SW'(C2) + SW'(x[31:24]) * SW'(C3);
	end

	// The truncated reciprocal gives the quotient or one less.
	assign prod = PW'(sum_s2) * PW'(RECIP);
	assign diff = sum_s3 - SW'(q_s3) * SW'(MOD);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sum_s2 <= sum_d;
		end
		if (en.s3) begin
			sum_s3 <= sum_s2;
			q_s3   <= prod[SW +: QW];
		end
		if (en.s4) begin
			r_s4 <= RW'((diff >= SW'(MOD)) ? (diff - SW'(MOD)) : diff);
		end
	end

endmodule

@@ rtl/mtp_shade.sv @@
// Last two stages: bar index, checkerboard and box test, then the final color.
// Depends on mtp_pkg for constants, the bar color table and the enable struct.
module mtp_shade #(
	parameter int FRAME_WIDTH  = 480,
	parameter int FRAME_HEIGHT = 480
) (
	input  logic                  clk,
	input  mtp_pkg::shade_en_t    en,
	input  logic [8:0]            px,
	input  logic [8:0]            py,
	input  logic                  cxy,
	input  logic [$clog2(FRAME_WIDTH+1)-1:0] shift,
	input  logic [$clog2(mtp_pkg::CHECK_MOD+1)-1:0] phase,
	input  logic [$clog2(((FRAME_WIDTH > mtp_pkg::BOX_W)
		? (FRAME_WIDTH - mtp_pkg::BOX_W) : 1)+1)-1:0] bx,
	input  logic [$clog2(((FRAME_HEIGHT > mtp_pkg::BOX_H)
		? (FRAME_HEIGHT - mtp_pkg::BOX_H) : 1)+1)-1:0] by,
	output logic [15:0]           color_s6
);

	localparam int PH_W = $clog2(mtp_pkg::CHECK_MOD + 1);
	localparam int VMAX = 511 + FRAME_WIDTH - 1;
	localparam int VW   = $clog2(VMAX + 1);
	localparam int YW   = $clog2(FRAME_HEIGHT + 512);
	localparam int BK   = $clog2(mtp_pkg::BAR_WIDTH * VMAX + 1);
	localparam int BR   = (1 << BK) / mtp_pkg::BAR_WIDTH + 1;
	localparam int BRW  = $clog2(BR + 1);
	localparam int QB   = $clog2(VMAX / mtp_pkg::BAR_WIDTH + 1);
	localparam int PW   = VW + BRW;

	logic [VW-1:0] pos;
	logic [PW-1:0] prod;
	logic          hit;
	logic          chk;
	logic [QB-1:0] bar_s5;
	logic          hit_s5;
	logic          chk_s5;

	assign pos  = VW'(px) + VW'(shift);
	// Rounded-up reciprocal of the bar width is exact over the whole position range.
	assign prod = PW'(pos) * PW'(BR);
	assign chk  = cxy ^ (phase >= PH_W'(mtp_pkg::CHECK_PERIOD));
	assign hit  = (VW'(px) >= VW'(bx)) && (VW'(px) < VW'(bx) + VW'(mtp_pkg::BOX_W))
		&& (YW'(py) >= YW'(by)) && (YW'(py) < YW'(by) + YW'(mtp_pkg::BOX_H));

	always_ff @(posedge clk) begin
		if (en.s5) begin
			bar_s5 <= prod[BK +: QB];
			hit_s5 <= hit;
			chk_s5 <= chk;
		end
		if (en.s6) begin
			if (hit_s5) begin
				color_s6 <= mtp_pkg::BOX_COLOR;
			end else begin
				color_s6 <= mtp_pkg::bar_color(mtp_pkg::BAR_IDX_W'(bar_s5))
					^ (chk_s5 ? mtp_pkg::CHECK_MASK : 16'h0000);
			end
		end
	end

endmodule

@@ rtl/moving_test_pattern_pixel.sv @@
// Top level of the animated test pattern: pipeline control and frame-derived terms.
// Depends on mtp_pkg, mtp_modc and mtp_shade.
//
//   channel   direction  handshake                 payload
//   coord     in         coord_valid/coord_stall   pixel_x, pixel_y, frame_number
//   color     out        color_valid/color_stall   pixel_color
//
// One word enters per cycle while coord_stall is low; each passes stages s1 to s6 before color_valid.
// The pipeline holds the three-stage remainder units (byte fold, reciprocal
// multiply, correction) between a front stage and two shading stages.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stall on the color side holds the last stage; earlier stages keep filling
// bubbles, and coord_stall rises only when every stage ahead is occupied.
module moving_test_pattern_pixel #(
	parameter int FRAME_WIDTH  = 480,
	parameter int FRAME_HEIGHT = 480
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        coord_valid,
	output logic        coord_stall,
	input  logic [8:0]  pixel_x,
	input  logic [8:0]  pixel_y,
	input  logic [31:0] frame_number,
	output logic        color_valid,
	input  logic        color_stall,
	output logic [15:0] pixel_color
);

	localparam int BOX_MOD_X = (FRAME_WIDTH > mtp_pkg::BOX_W)
		? (FRAME_WIDTH - mtp_pkg::BOX_W) : 1;
	localparam int BOX_MOD_Y = (FRAME_HEIGHT > mtp_pkg::BOX_H)
		? (FRAME_HEIGHT - mtp_pkg::BOX_H) : 1;
	localparam int SHIFT_W = $clog2(FRAME_WIDTH + 1);
	localparam int BX_W    = $clog2(BOX_MOD_X + 1);
	localparam int BY_W    = $clog2(BOX_MOD_Y + 1);
	localparam int PH_W    = $clog2(mtp_pkg::CHECK_MOD + 1);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic [8:0]  px_s1, px_s2, px_s3, px_s4;
	logic [8:0]  py_s1, py_s2, py_s3, py_s4;
	logic        cxy_s1, cxy_s2, cxy_s3, cxy_s4;
	logic [31:0] fr_s1;
	logic [31:0] p7_s1;
	logic [31:0] p3_s1;

	logic [mtp_pkg::CHECK_PROD_W-1:0] qx_prod;
	logic [mtp_pkg::CHECK_PROD_W-1:0] qy_prod;

	logic [SHIFT_W-1:0] shift_s4;
	logic [PH_W-1:0]    phase_s4;
	logic [BX_W-1:0]    bx_s4;
	logic [BY_W-1:0]    by_s4;
	logic [15:0]        color_s6;

	mtp_pkg::mod_en_t   men;
	mtp_pkg::shade_en_t sen;

	// A stage can load when it is empty or the stage after it loads too.
	always_comb begin
		rdy6 = !vld_s6 || !color_stall;
		rdy5 = !vld_s5 || rdy6;
		rdy4 = !vld_s4 || rdy5;
		rdy3 = !vld_s3 || rdy4;
		rdy2 = !vld_s2 || rdy3;
		rdy1 = !vld_s1 || rdy2;
	end

	assign coord_stall = !rdy1;
	assign color_valid = vld_s6;
	assign pixel_color = color_s6;

	assign men.s2 = rdy2;
	assign men.s3 = rdy3;
	assign men.s4 = rdy4;
	assign sen.s5 = rdy5;
	assign sen.s6 = rdy6;

	assign qx_prod = mtp_pkg::CHECK_PROD_W'(pixel_x)
		* mtp_pkg::CHECK_PROD_W'(mtp_pkg::CHECK_RECIP);
	assign qy_prod = mtp_pkg::CHECK_PROD_W'(pixel_y)
		* mtp_pkg::CHECK_PROD_W'(mtp_pkg::CHECK_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= coord_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			px_s1  <= pixel_x;
			py_s1  <= pixel_y;
			fr_s1  <= frame_number;
			// Box steps wrap at 32 bits, as the frame count does.
			p7_s1  <= {frame_number[28:0], 3'b000} - frame_number;
			p3_s1  <= {frame_number[30:0], 1'b0} + frame_number;
			cxy_s1 <= qx_prod[mtp_pkg::CHECK_SHIFT] ^ qy_prod[mtp_pkg::CHECK_SHIFT];
		end
		if (rdy2) begin
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			cxy_s2 <= cxy_s1;
		end
		if (rdy3) begin
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			cxy_s3 <= cxy_s2;
		end
		if (rdy4) begin
			px_s4  <= px_s3;
			py_s4  <= py_s3;
			cxy_s4 <= cxy_s3;
		end
	end

	mtp_modc #(.MOD(FRAME_WIDTH)) u_shift (
		.clk  (clk),
		.en   (men),
		.x    (fr_s1),
		.r_s4 (shift_s4)
	);

	mtp_modc #(.MOD(mtp_pkg::CHECK_MOD)) u_phase (
		.clk  (clk),
		.en   (men),
		.x    (fr_s1),
		.r_s4 (phase_s4)
	);

	mtp_modc #(.MOD(BOX_MOD_X)) u_box_x (
		.clk  (clk),
		.en   (men),
		.x    (p7_s1),
		.r_s4 (bx_s4)
	);

	mtp_modc #(.MOD(BOX_MOD_Y)) u_box_y (
		.clk  (clk),
		.en   (men),
		.x    (p3_s1),
		.r_s4 (by_s4)
	);

	mtp_shade #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_shade (
		.clk      (clk),
		.en       (sen),
		.px       (px_s4),
		.py       (py_s4),
		.cxy      (cxy_s4),
		.shift    (shift_s4),
		.phase    (phase_s4),
		.bx       (bx_s4),
		.by       (by_s4),
		.color_s6 (color_s6)
	);

endmodule

@@ rtl/mtp_check.sv @@
// Port-level checker for the moving test pattern block, with its bind statement.
// Depends on the assertion macros in moving_test_pattern_pixel_assert.svh.
`include "moving_test_pattern_pixel_assert.svh"

module mtp_check (
	input logic        clk,
	input logic        arst_n,
	input logic        coord_valid,
	input logic        coord_stall,
	input logic        color_valid,
	input logic        color_stall,
	input logic [15:0] pixel_color
);

	localparam int DEPTH = 6;

	logic       acc_in;
	logic       acc_out;
	logic [3:0] occ_q;

	assign acc_in  = coord_valid && !coord_stall;
	assign acc_out = color_valid && !color_stall;

	// Words accepted and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 4'd0;
		end else begin
			occ_q <= occ_q + 4'(acc_in) - 4'(acc_out);
		end
	end

	`MTP_ASSERT_NOW(a_no_phantom, color_valid, occ_q != 4'd0)
	`MTP_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= 4'(DEPTH))
	`MTP_ASSERT_NOW(a_empty_out_accepts, !color_valid, !coord_stall)
	`MTP_ASSERT_NEXT(a_out_hold, color_valid && color_stall, color_valid && $stable(pixel_color))

endmodule

bind moving_test_pattern_pixel mtp_check u_check (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for moving_test_pattern_pixel: random coordinates and frame numbers
// against a behavioral model of the bars, checkerboard and box. Depends on mtp_pkg and the RTL.
module testbench;

	localparam int FRAME_W        = 480;
	localparam int FRAME_H        = 480;
	localparam int BAR_COUNT      = 6;
	localparam int CHECK_SQUARE   = 24;
	localparam int RANDOM_WORDS   = 1228;
	localparam int QUIET_FIRST    = 300;
	localparam int QUIET_LAST     = 500;
	localparam int HOLD_AT        = 900;
	localparam int HOLD_CYCLES    = 60;
	localparam int DRAIN_AT       = 700;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int FLUSH_CYCLES   = 20;

	typedef struct {
		logic [8:0]  x;
		logic [8:0]  y;
		logic [31:0] frame;
		bit          drain;
	} coord_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        coord_valid = 1'b0;
	logic        coord_stall;
	logic [8:0]  pixel_x = '0;
	logic [8:0]  pixel_y = '0;
	logic [31:0] frame_number = '0;
	logic        color_valid;
	logic        color_stall = 1'b0;
	logic [15:0] pixel_color;

	coord_word_t coord_q[$];
	logic [15:0] color_exp[$];
	logic [15:0] color_want;
	int          words_in;
	int          words_out;
	int          words_next;
	int          hold_left;
	bit          hold_done;
	int          quiet_cycles;
	int          errors = 0;

	moving_test_pattern_pixel #(
		.FRAME_WIDTH(FRAME_W),
		.FRAME_HEIGHT(FRAME_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.coord_valid(coord_valid),
		.coord_stall(coord_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.frame_number(frame_number),
		.color_valid(color_valid),
		.color_stall(color_stall),
		.pixel_color(pixel_color)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The box position uses the 32-bit wrapped product of the frame number.
	function automatic logic [31:0] box_left_of(input logic [31:0] fr);
		return (fr * 32'd7) % (FRAME_W - mtp_pkg::BOX_W);
	endfunction

	function automatic logic [31:0] box_top_of(input logic [31:0] fr);
		return (fr * 32'd3) % (FRAME_H - mtp_pkg::BOX_H);
	endfunction

	function automatic logic [15:0] pattern_color(input logic [8:0] px, input logic [8:0] py,
			input logic [31:0] fr);
		logic [31:0] bar_idx;
		logic [31:0] phase;
		logic [31:0] left;
		logic [31:0] top;
		logic [15:0] c;
		bar_idx = ((32'(px) + fr % FRAME_W) / mtp_pkg::BAR_WIDTH) % BAR_COUNT;
		case (bar_idx)
			0: c = mtp_pkg::COLOR_RED;
			1: c = mtp_pkg::COLOR_GREEN;
			2: c = mtp_pkg::COLOR_BLUE;
			3: c = mtp_pkg::COLOR_WHITE;
			4: c = mtp_pkg::COLOR_BLACK;
			default: c = mtp_pkg::COLOR_YELLOW;
		endcase
		phase = 32'(px / CHECK_SQUARE) ^ 32'(py / CHECK_SQUARE)
			^ (fr / mtp_pkg::CHECK_PERIOD);
		if (phase[0])
			c = c ^ mtp_pkg::CHECK_MASK;
		left = box_left_of(fr);
		top = box_top_of(fr);
		if (px >= left && px < left + mtp_pkg::BOX_W
				&& py >= top && py < top + mtp_pkg::BOX_H)
			c = mtp_pkg::BOX_COLOR;
		return c;
	endfunction

	task automatic queue_pixel(input int x, input int y, input logic [31:0] fr, input bit drain);
		coord_word_t w;
		w.x = x[8:0];
		w.y = y[8:0];
		w.frame = fr;
		w.drain = drain;
		coord_q.push_back(w);
	endtask

	// Sender: a word is held until accepted; a word marked drain waits until all results are in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_valid <= 1'b0;
			pixel_x <= '0;
			pixel_y <= '0;
			frame_number <= '0;
			words_in <= 0;
		end else begin
			words_next = words_in;
			if (coord_valid && !coord_stall) begin
				color_exp.push_back(pattern_color(pixel_x, pixel_y, frame_number));
				words_next = words_in + 1;
			end
			words_in <= words_next;
			if (!(coord_valid && coord_stall)) begin
				if (coord_q.size() == 0)
					coord_valid <= 1'b0;
				else if (coord_q[0].drain && words_next != words_out)
					coord_valid <= 1'b0;
				else if (!(words_next >= QUIET_FIRST && words_next < QUIET_LAST)
						&& $urandom_range(0, 99) < 22)
					coord_valid <= 1'b0;
				else begin
					coord_valid <= 1'b1;
					pixel_x <= coord_q[0].x;
					pixel_y <= coord_q[0].y;
					frame_number <= coord_q[0].frame;
					void'(coord_q.pop_front());
				end
			end
		end
	end

	// Receiver: checks each word against the oldest prediction and decides its own stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_stall <= 1'b0;
			words_out <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (color_valid && !color_stall) begin
				words_out <= words_out + 1;
				if (color_exp.size() == 0) begin
					$error("pixel_color: expected none, actual %h", pixel_color);
					errors++;
				end else begin
					color_want = color_exp.pop_front();
					if (pixel_color !== color_want) begin
						$error("pixel_color: expected %h, actual %h", color_want, pixel_color);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				color_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && words_out >= HOLD_AT) begin
				// Long hold-off so the pipeline fills and the input side has to stall.
				color_stall <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				hold_done <= 1'b1;
			end else if (words_out >= QUIET_FIRST && words_out < QUIET_LAST)
				color_stall <= 1'b0;
			else
				color_stall <= ($urandom_range(0, 99) < 22);
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((coord_valid && !coord_stall) || (color_valid && !color_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : stimulus
		logic [31:0] fr;
		int left;
		int top;
		int x;
		int y;
		int kind;

		// Each bar color at frame zero, clear of the box.
		for (int i = 0; i < BAR_COUNT; i++)
			queue_pixel(i * mtp_pkg::BAR_WIDTH, 100, 32'd0, 1'b0);
		// Checkerboard phase around its flips.
		queue_pixel(30, 100, 32'd29, 1'b0);
		queue_pixel(30, 100, 32'd30, 1'b0);
		queue_pixel(30, 100, 32'd59, 1'b0);
		queue_pixel(30, 100, 32'd60, 1'b0);
		// Field extremes and coordinates beyond the frame.
		queue_pixel(0, 0, 32'd0, 1'b0);
		queue_pixel(511, 511, 32'hFFFF_FFFF, 1'b0);
		queue_pixel(0, 511, 32'hFFFF_FFFF, 1'b0);
		queue_pixel(479, 479, 32'd479, 1'b0);
		queue_pixel(480, 0, 32'd480, 1'b0);
		queue_pixel(511, 0, 32'h8000_0000, 1'b0);
		// Box edges at a frame whose product by seven wraps past 32 bits.
		fr = 32'h2492_4925;
		left = box_left_of(fr);
		top = box_top_of(fr);
		queue_pixel(left, top, fr, 1'b0);
		queue_pixel(left + mtp_pkg::BOX_W - 1, top + mtp_pkg::BOX_H - 1, fr, 1'b0);
		queue_pixel(left + mtp_pkg::BOX_W, top, fr, 1'b0);
		queue_pixel(left - 1, top, fr, 1'b0);
		queue_pixel(left, top + mtp_pkg::BOX_H, fr, 1'b0);
		queue_pixel(left, top - 1, fr, 1'b0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			kind = $urandom_range(0, 9);
			fr = (kind < 3) ? $urandom : $urandom_range(0, 4000);
			if (kind % 2 == 0) begin
				// Aim at the box and just around its borders.
				x = int'(box_left_of(fr)) + $urandom_range(0, mtp_pkg::BOX_W + 7) - 4;
				y = int'(box_top_of(fr)) + $urandom_range(0, mtp_pkg::BOX_H + 7) - 4;
			end else begin
				x = $urandom_range(0, 511);
				y = $urandom_range(0, 511);
			end
			queue_pixel(x, y, fr, i == DRAIN_AT);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (coord_q.size() != 0 || coord_valid)
			@(posedge clk);
		while (color_exp.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);

		if (color_exp.size() != 0)
			$error("pixel_color: %0d expected words never arrived", color_exp.size());
		if (errors == 0 && color_exp.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
